FILE: hdl/gmr_pkg.sv
// Shared types and constants for the gap-method merge block.
// Used by gmr_store, gmr_ctrl and the top level.
`timescale 1ns / 1ps

package gmr_pkg;

  // Width of one stored element and of the first-run length register.
  localparam int unsigned DataW = 32;
  localparam int unsigned FrlW  = 7;

  // Flags that travel with one merged result from the sequencer to the ports.
  typedef struct packed {
    logic valid;
    logic in_first_run;
    logic last_result;
    logic overflow;
  } res_t;

endpackage

FILE: hdl/gap_merge_two_sorted_runs.sv
// Top level of the gap-method merge of two sorted runs, with its register port.
// Depends on gmr_pkg, gmr_store and gmr_ctrl.
`timescale 1ns / 1ps

// Items are taken one per cycle while busy is low. The item with last_item
// raises busy, and the block then runs the gap passes over its single store,
// each pair being read, compared and, when swapped, written back in two steps,
// as the store has one write port. The merged set is then read out. Results
// leave at one per cycle with res_valid_o high for exactly one cycle each, in
// the cycle after the read; the receiver cannot stall them, so it must take
// every transfer. busy falls on the cycle that shows the last result, and a new
// item may be taken while the last result is on the ports.
module gap_merge_two_sorted_runs #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Item channel.
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  value_i,
  input  logic                last_item_i,
  // Result channel.
  output logic                res_valid_o,
  output logic signed [31:0]  value_res_o,
  output logic                in_first_run_o,
  output logic                last_result_o,
  output logic                overflow_o,
  // Register port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import gmr_pkg::*;

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  logic [FrlW-1:0]  frl_q;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [DataW-1:0] wdata;
  logic [AddrW-1:0] raddr_a;
  logic [AddrW-1:0] raddr_b;
  logic [DataW-1:0] rdata_a;
  logic [DataW-1:0] rdata_b;
  res_t             res;

  // First-run length register at byte address 0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frl_q <= '0;
    end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
      frl_q <= pwdata[FrlW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {{(32-FrlW){1'b0}}, frl_q} : 32'd0;

  gmr_store #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  gmr_ctrl #(
    .Capacity (CAPACITY),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .value_i            (value_i),
    .last_item_i        (last_item_i),
    .first_run_length_i (frl_q),
    .busy_o             (busy),
    .res_o              (res),
    .we_o               (we),
    .waddr_o            (waddr),
    .wdata_o            (wdata),
    .raddr_a_o          (raddr_a),
    .raddr_b_o          (raddr_b),
    .rdata_a_i          (rdata_a),
    .rdata_b_i          (rdata_b)
  );

  // Result ports: value straight from the store's read register.
  assign res_valid_o    = res.valid;
  assign value_res_o    = $signed(rdata_a);
  assign in_first_run_o = res.in_first_run;
  assign last_result_o  = res.last_result;
  assign overflow_o     = res.overflow;

endmodule

FILE: hdl/gmr_store.sv
// Element store of the merge block: one write port, two registered read ports.
// Depends on gmr_pkg for the element width.
`timescale 1ns / 1ps

module gmr_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [gmr_pkg::DataW-1:0] wdata_i,
  input  logic [AddrW-1:0]          raddr_a_i,
  input  logic [AddrW-1:0]          raddr_b_i,
  output logic [gmr_pkg::DataW-1:0] rdata_a_o,
  output logic [gmr_pkg::DataW-1:0] rdata_b_o
);
  import gmr_pkg::*;

  logic [DataW-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: hdl/gmr_ctrl.sv
// Sequencer of the merge block: loads items, runs the gap passes over the
// store by read, compare and write-back, then reads the merged set out.
// Depends on gmr_pkg and drives the ports of gmr_store.
`timescale 1ns / 1ps

module gmr_ctrl #(
  parameter int unsigned Capacity = 64,
  parameter int unsigned AddrW    = 6,
  parameter int unsigned CntW     = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gmr_pkg::DataW-1:0] value_i,
  input  logic                      last_item_i,
  input  logic [gmr_pkg::FrlW-1:0]  first_run_length_i,
  output logic                      busy_o,
  output gmr_pkg::res_t             res_o,
  output logic                      we_o,
  output logic [AddrW-1:0]          waddr_o,
  output logic [gmr_pkg::DataW-1:0] wdata_o,
  output logic [AddrW-1:0]          raddr_a_o,
  output logic [AddrW-1:0]          raddr_b_o,
  input  logic [gmr_pkg::DataW-1:0] rdata_a_i,
  input  logic [gmr_pkg::DataW-1:0] rdata_b_i
);
  import gmr_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD,
    S_CMP,
    S_WR2,
    S_EMIT
  } state_e;

  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             dropped_q, dropped_d;
  logic [CntW-1:0]  total_q, total_d;
  logic [CntW-1:0]  gap_q, gap_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  pos_q, pos_d;
  logic [DataW-1:0] hold_q, hold_d;
  res_t             res_q, res_d;

  logic             stored;
  logic [CntW-1:0]  load_total;
  logic             swap;
  logic [CntW:0]    pair_end;
  logic [CntW-1:0]  pair_hi;
  logic [CntW-1:0]  gap_half;
  logic [CntW-1:0]  first_gap;

  // Address of the upper element of the current pair and the end test of a pass.
  assign pair_hi  = idx_q + gap_q;
  assign pair_end = {1'b0, idx_q} + {1'b0, gap_q} + (CntW+1)'(1);
  assign gap_half = CntW'(({1'b0, gap_q} + (CntW+1)'(1)) >> 1);

  // Loading: an item is stored while there is room, otherwise it is dropped.
  assign stored     = (count_q < CapCnt);
  assign load_total = stored ? (count_q + CntW'(1)) : count_q;
  assign first_gap  = CntW'(({1'b0, load_total} + (CntW+1)'(1)) >> 1);

  // The lower element must move up when it holds the greater signed value.
  assign swap = ($signed(rdata_a_i) > $signed(rdata_b_i));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    total_d   = total_q;
    gap_d     = gap_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    hold_d    = hold_q;
    res_d     = '0;
    we_o      = 1'b0;
    waddr_o   = count_q[AddrW-1:0];
    wdata_o   = value_i;
    raddr_a_o = idx_q[AddrW-1:0];
    raddr_b_o = pair_hi[AddrW-1:0];

    case (state_q)
      S_LOAD: begin
        if (start_i) begin
          if (stored) begin
            we_o    = 1'b1;
            count_d = count_q + CntW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (last_item_i) begin
            total_d = load_total;
            idx_d   = '0;
            pos_d   = '0;
            if (load_total > CntW'(1)) begin
              gap_d   = first_gap;
              state_d = S_RD;
            end else begin
              state_d = S_EMIT;
            end
          end
        end
      end

      // Both elements of the pair are read in this cycle.
      S_RD: begin
        state_d = S_CMP;
      end

      // Compare; on a swap the lower slot takes the smaller value now.
      S_CMP: begin
        if (swap) begin
          we_o    = 1'b1;
          waddr_o = idx_q[AddrW-1:0];
          wdata_o = rdata_b_i;
          hold_d  = rdata_a_i;
          state_d = S_WR2;
        end
      end

      // Second half of a swap: the upper slot takes the greater value.
      S_WR2: begin
        we_o    = 1'b1;
        waddr_o = pair_hi[AddrW-1:0];
        wdata_o = hold_q;
      end

      // One read issued per cycle; the result shows on the next cycle.
      S_EMIT: begin
        raddr_a_o          = pos_q[AddrW-1:0];
        res_d.valid        = 1'b1;
        res_d.in_first_run = (FrlW'(pos_q) < first_run_length_i);
        res_d.last_result  = ((pos_q + CntW'(1)) == total_q);
        res_d.overflow     = dropped_q;
        pos_d              = pos_q + CntW'(1);
        if ((pos_q + CntW'(1)) == total_q) begin
          count_d   = '0;
          dropped_d = 1'b0;
          state_d   = S_LOAD;
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase

    // Step to the next pair, the next pass, or read-out once gap 1 is done.
    if ((state_q == S_WR2) || ((state_q == S_CMP) && !swap)) begin
      if (pair_end < {1'b0, total_q}) begin
        idx_d   = idx_q + CntW'(1);
        state_d = S_RD;
      end else if (gap_q == CntW'(1)) begin
        pos_d   = '0;
        state_d = S_EMIT;
      end else begin
        gap_d   = gap_half;
        idx_d   = '0;
        state_d = S_RD;
      end
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      count_q   <= '0;
      dropped_q <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      res_q     <= res_d;
    end
  end

  // Working registers of the passes and the read-out.
  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    gap_q   <= gap_d;
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    hold_q  <= hold_d;
  end

  assign busy_o = (state_q != S_LOAD);
  assign res_o  = res_q;

endmodule

FILE: hdl/gmr_checker.sv
// Port-level checks of the merge block's sequencing, bound to the top level.
// Depends on gap_merge_two_sorted_runs only through its ports.
`timescale 1ns / 1ps

module gmr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic last_item_i,
  input logic res_valid_o,
  input logic last_result_o
);

  // A result only follows a cycle in which the block was busy reading out.
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result transfer without a preceding busy cycle");

  // An item without the last mark leaves the block ready for the next one.
  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !last_item_i) |=> !busy)
    else $error("busy raised by an unmarked item");

  // The marked item starts the merge.
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_item_i) |=> busy)
    else $error("marked item did not start the merge");

  // Results of one set leave on consecutive cycles up to the last one.
  a_res_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_result_o) |=> res_valid_o)
    else $error("gap inside a result burst");

  // Nothing follows the last result of a set.
  a_none_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && last_result_o) |=> !res_valid_o)
    else $error("result transfer after the last result");

endmodule

bind gap_merge_two_sorted_runs gmr_checker u_gmr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .last_item_i   (last_item_i),
  .res_valid_o   (res_valid_o),
  .last_result_o (last_result_o)
);

FILE: bench/testbench.sv
// Self-checking testbench for gap_merge_two_sorted_runs, driven through its command
// and register ports; results are predicted in-bench and checked one by one.
// Depends on gmr_pkg and the RTL of the merge block only.
`timescale 1ns / 1ps

module testbench;
  import gmr_pkg::*;

  localparam int unsigned Capacity    = 64;
  localparam int          RandomItems = 60;
  localparam int          IdleCycles  = 8;
  localparam int          DrainLimit  = 20000;
  localparam logic [1:0]  FrlAddr     = 2'd0;

  // One merged element as it should appear on the result ports.
  typedef struct {
    logic signed [DataW-1:0] value;
    logic                    in_first_run;
    logic                    last_result;
    logic                    overflow;
  } merged_item_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic signed [DataW-1:0] value_i;
  logic                    last_item_i;
  logic                    res_valid_o;
  logic signed [DataW-1:0] value_res_o;
  logic                    in_first_run_o;
  logic                    last_result_o;
  logic                    overflow_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [1:0]              paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  // Predictor state: the stored set, its fill level and the first-run length.
  logic signed [DataW-1:0] set_store [Capacity];
  int                      stored_count;
  bit                      items_dropped;
  logic [FrlW-1:0]         first_run_len;
  merged_item_t            merged_q [$];
  int                      errors;
  int                      items_sent;
  bit                      no_gaps;

  gap_merge_two_sorted_runs #(
    .CAPACITY(Capacity)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .value_i       (value_i),
    .last_item_i   (last_item_i),
    .res_valid_o   (res_valid_o),
    .value_res_o   (value_res_o),
    .in_first_run_o(in_first_run_o),
    .last_result_o (last_result_o),
    .overflow_o    (overflow_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock with a 4 ns period.
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Gap-method merge of the predicted store, passes at gap ceil(n/2) down to 1.
  function automatic void merge_store(input int total);
    int                      gap;
    bit                      final_pass;
    logic signed [DataW-1:0] held;
    if (total >= 2) begin
      gap = (total + 1) / 2;
      do begin
        for (int i = 0; i + gap < total; i++) begin
          if (set_store[i] > set_store[i + gap]) begin
            held               = set_store[i];
            set_store[i]       = set_store[i + gap];
            set_store[i + gap] = held;
          end
        end
        final_pass = (gap <= 1);
        gap        = (gap + 1) / 2;
      end while (!final_pass);
    end
  endfunction

  // Mostly full-range values, with extremes and small values that give duplicates.
  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return $signed($urandom_range(0, 16)) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  // Sends one item, holding start until the transfer, then updates the predictor.
  task automatic send_item(input logic signed [DataW-1:0] value, input bit last);
    merged_item_t expected;
    @(negedge clk_i);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 7) begin
        start = 1'b0;
        @(negedge clk_i);
      end
    end
    start       = 1'b1;
    value_i     = value;
    last_item_i = last;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (stored_count < Capacity) begin
      set_store[stored_count] = value;
      stored_count++;
    end else begin
      items_dropped = 1'b1;
    end
    if (last) begin
      merge_store(stored_count);
      for (int k = 0; k < stored_count; k++) begin
        expected.value        = set_store[k];
        expected.in_first_run = (k < first_run_len);
        expected.last_result  = (k + 1 == stored_count);
        expected.overflow     = items_dropped;
        merged_q.insert(merged_q.size(), expected);
      end
      stored_count  = 0;
      items_dropped = 1'b0;
    end
  endtask

  // Lowers start, waits for every expected result, then lets the block settle.
  task automatic settle();
    int guard;
    @(negedge clk_i);
    start = 1'b0;
    guard = 0;
    while (merged_q.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    if (merged_q.size() != 0) begin
      $error("%0d merged results never arrived", merged_q.size());
      errors++;
      merged_q.delete();
    end
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  // Writes the first-run length over the register port and reads it back.
  task automatic write_first_run_length(input logic [FrlW-1:0] len);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = FrlAddr;
    pwdata  = 32'(len);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    first_run_len = len;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(len)) begin
      $error("prdata: expected %0d, got %0d", len, prdata);
      errors++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Sends one set: a first run, then a second run, each sorted unless asked not to be.
  task automatic load_set(input int first_n, input int second_n, input bit ascending);
    logic signed [DataW-1:0] vals [0:127];
    logic signed [DataW-1:0] held;
    int                      total;
    int                      j;
    total = first_n + second_n;
    for (int i = 0; i < total; i++) vals[i] = pick_value();
    if (ascending) begin
      // Insertion sort that never crosses the boundary between the two runs.
      for (int i = 1; i < total; i++) begin
        j = i;
        while (j > 0 && j != first_n && vals[j - 1] > vals[j]) begin
          held        = vals[j];
          vals[j]     = vals[j - 1];
          vals[j - 1] = held;
          j--;
        end
      end
    end
    for (int i = 0; i < total; i++) send_item(vals[i], i == total - 1);
  endtask

  // Short sets that cover the value extremes, duplicates, single items and
  // first-run lengths of zero, within the set and beyond it.
  task automatic test_directed_sets();
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h8000_0000, 1'b1);
    settle();
    write_first_run_length(7'd1);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7fff_ffff, 1'b1);
    send_item(-32'sd1, 1'b1);
    settle();
    write_first_run_length(7'd3);
    send_item(-32'sd5, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(32'sd9, 1'b0);
    send_item(-32'sd7, 1'b0);
    send_item(32'sd3, 1'b0);
    send_item(32'sd3, 1'b1);
    // Runs out of order still go through the same passes.
    send_item(32'sd5, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sd4, 1'b0);
    send_item(-32'sd2, 1'b1);
    settle();
    write_first_run_length(7'd64);
    send_item(32'sd10, 1'b0);
    send_item(32'sd20, 1'b0);
    send_item(32'sd30, 1'b1);
    settle();
    write_first_run_length(7'd0);
    send_item(32'sd0, 1'b0);
    send_item(32'sd0, 1'b1);
    settle();
  endtask

  // A full store, two overflows in which the marked item is dropped, and a
  // small set afterwards to see the overflow flag cleared.
  task automatic test_store_capacity();
    write_first_run_length(7'd40);
    load_set(30, 34, 1'b1);
    load_set(40, 25, 1'b1);
    load_set(32, 34, 1'b1);
    load_set(1, 2, 1'b1);
    settle();
  endtask

  // Random sets in phases, each phase under its own first-run length.
  task automatic test_random_sets();
    int first_sent;
    int phase;
    int kind;
    int n;
    first_sent = items_sent;
    phase      = 0;
    while (items_sent - first_sent < RandomItems) begin
      case ($urandom_range(0, 3))
        0:       write_first_run_length(7'd0);
        1:       write_first_run_length(7'd64);
        default: write_first_run_length(7'($urandom_range(0, 64)));
      endcase
      no_gaps = (phase == 0);
      repeat ($urandom_range(2, 5)) begin
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          load_set($urandom_range(0, 8), $urandom_range(1, 8), 1'b1);
        end else if (kind < 85) begin
          load_set($urandom_range(0, 32), $urandom_range(1, 32), 1'b1);
        end else if (kind < 90) begin
          n = $urandom_range(1, 63);
          load_set(n, Capacity - n + $urandom_range(0, 2), 1'b1);
        end else begin
          load_set($urandom_range(0, 12), $urandom_range(1, 12), 1'b0);
        end
      end
      settle();
      phase++;
    end
    no_gaps = 1'b0;
  endtask

  // Each result transfer is compared with the oldest expectation.
  always @(posedge clk_i) begin
    merged_item_t expected;
    if (rst_ni && res_valid_o === 1'b1) begin
      if (merged_q.size() == 0) begin
        $error("unexpected result: value_res %0d", value_res_o);
        errors++;
      end else begin
        expected = merged_q.pop_front();
        if (value_res_o !== expected.value) begin
          $error("value_res: expected %0d, got %0d", expected.value, value_res_o);
          errors++;
        end
        if (in_first_run_o !== expected.in_first_run) begin
          $error("in_first_run: expected %0b, got %0b", expected.in_first_run,
                 in_first_run_o);
          errors++;
        end
        if (last_result_o !== expected.last_result) begin
          $error("last_result: expected %0b, got %0b", expected.last_result,
                 last_result_o);
          errors++;
        end
        if (overflow_o !== expected.overflow) begin
          $error("overflow: expected %0b, got %0b", expected.overflow, overflow_o);
          errors++;
        end
      end
    end
  end

  // Hard limit on the run time.
  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    value_i       = '0;
    last_item_i   = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = FrlAddr;
    pwdata        = '0;
    stored_count  = 0;
    items_dropped = 1'b0;
    first_run_len = '0;
    errors        = 0;
    items_sent    = 0;
    no_gaps       = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_sets();
    test_store_capacity();
    test_random_sets();
    settle();

    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
